@@ design/pcdwf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcdwf_pkg
// Shared types and constants for the per-channel duplicate window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdwf_pkg;

  localparam int unsigned ChanW  = 4;
  localparam int unsigned DataW  = 32;
  localparam logic [DataW-1:0] WindowReset = 32'd50;

  // One slot of the channel table.
  typedef struct packed {
    logic [DataW-1:0] fingerprint;
    logic [DataW-1:0] time_ms;
    logic [DataW-1:0] drops;
  } entry_t;

  // Write-back request into the channel table.
  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] idx;
    entry_t           entry;
  } wr_req_t;

endpackage

`default_nettype wire

@@ design/pcdwf_if.sv @@
// ----------------------------------------------------------------------------
// pcdwf_in_if / pcdwf_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcdwf_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcdwf_pkg::ChanW-1:0]  channel;
  logic [pcdwf_pkg::DataW-1:0]  message_fingerprint;
  logic [pcdwf_pkg::DataW-1:0]  time_now_ms;

  modport source (output valid, channel, message_fingerprint, time_now_ms, input ready);
  modport sink   (input valid, channel, message_fingerprint, time_now_ms, output ready);
endinterface

interface pcdwf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_duplicate;
  logic [pcdwf_pkg::DataW-1:0]  channel_drops;

  modport source (output valid, is_duplicate, channel_drops, input ready);
  modport sink   (input valid, is_duplicate, channel_drops, output ready);
endinterface

`default_nettype wire

@@ design/pcdwf_table.sv @@
// ----------------------------------------------------------------------------
// pcdwf_table
// Channel slot memory with registered read, per-entry valid flops and
// write-to-read forwarding for a read issued in the write-back cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdwf_table #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           rd_en_i,
  input  wire [pcdwf_pkg::ChanW-1:0]    rd_idx_i,
  input  wire pcdwf_pkg::wr_req_t       wr_i,
  output logic                          rd_valid_o,
  output pcdwf_pkg::entry_t             rd_entry_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  pcdwf_pkg::entry_t mem [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic                rd_valid_q;
  pcdwf_pkg::entry_t   rd_entry_q;
  logic [IdxW-1:0]     rd_idx, wr_idx;
  logic                same_idx;

  assign rd_idx   = rd_idx_i[IdxW-1:0];
  assign wr_idx   = wr_i.idx[IdxW-1:0];
  assign same_idx = wr_i.en && (wr_i.idx == rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_idx] <= wr_i.entry;
    end
  end

  // Read data: the write of this same edge wins on a collision.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q <= same_idx ? wr_i.entry : mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= same_idx | valid_q[rd_idx];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_entry_o = rd_entry_q;

endmodule

`default_nettype wire

@@ design/per_channel_duplicate_window_filter_core.sv @@
// ----------------------------------------------------------------------------
// per_channel_duplicate_window_filter_core
// Drops repeated messages per channel inside a programmable time window.
// ----------------------------------------------------------------------------
// Each item names a channel, a message fingerprint and the current ms time.
// A channel holds its last accepted fingerprint and time plus a drop counter.
// An item whose fingerprint matches a valid slot and whose elapsed time
// (mod 2^32) is below window_ms is flagged duplicate and bumps the counter;
// any other item on an existing channel rewrites the slot. Channels at or
// above CHANNELS give a zero result and touch nothing. Every item yields
// exactly one result item. An accepted item is registered in s1 and its
// result in the output register when s1 advances; one item per cycle is
// sustained while out_o.ready stays high: the table is read at accept, the
// compare and write-back happen as s1 advances, and a read that collides
// with that write-back picks up the written data. Slot valid bits clear at
// reset, so there is no clearing pass. window_ms resets to 50 and must be
// written through cfg_we_i / cfg_wdata_i while the block is idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_duplicate_window_filter_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [pcdwf_pkg::DataW-1:0]    cfg_wdata_i,
  pcdwf_in_if.sink                      in_i,
  pcdwf_out_if.source                   out_o
);

  localparam int unsigned DataW = pcdwf_pkg::DataW;
  localparam int unsigned ChanW = pcdwf_pkg::ChanW;

  // Window register.
  logic [DataW-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= pcdwf_pkg::WindowReset;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // Compare stage (s1) and output register.
  logic             s1_valid_q;
  logic             s1_in_range_q;
  logic [ChanW-1:0] s1_ch_q;
  logic [DataW-1:0] s1_fp_q;
  logic [DataW-1:0] s1_now_q;

  logic             out_valid_q;
  logic             out_dup_q;
  logic [DataW-1:0] out_drops_q;

  logic             in_fire, s1_fire, in_range;
  logic             tbl_rd_valid;
  pcdwf_pkg::entry_t tbl_rd_entry;
  pcdwf_pkg::wr_req_t wr_req;

  logic             slot_hit, is_dup;
  logic [DataW-1:0] elapsed, drops_base, drops_new;

  // s1 advances when the output register is free or drains this cycle.
  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign in_range = {1'b0, in_i.channel} < (ChanW+1)'(CHANNELS);

  pcdwf_table #(
    .CHANNELS (CHANNELS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire && in_range),
    .rd_idx_i   (in_i.channel),
    .wr_i       (wr_req),
    .rd_valid_o (tbl_rd_valid),
    .rd_entry_o (tbl_rd_entry)
  );

  // Duplicate test on the slot read at accept.
  always_comb begin
    slot_hit   = s1_in_range_q && tbl_rd_valid;
    elapsed    = s1_now_q - tbl_rd_entry.time_ms;
    is_dup     = slot_hit && (tbl_rd_entry.fingerprint == s1_fp_q) &&
                 (elapsed < window_q);
    // a never-written slot counts as zero drops
    drops_base = slot_hit ? tbl_rd_entry.drops : '0;
    drops_new  = is_dup ? (drops_base + DataW'(1)) : drops_base;

    wr_req.en  = s1_fire && s1_in_range_q;
    wr_req.idx = s1_ch_q;
    wr_req.entry.drops       = drops_new;
    wr_req.entry.fingerprint = is_dup ? tbl_rd_entry.fingerprint : s1_fp_q;
    wr_req.entry.time_ms     = is_dup ? tbl_rd_entry.time_ms : s1_now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_in_range_q <= in_range;
      s1_ch_q       <= in_i.channel;
      s1_fp_q       <= in_i.message_fingerprint;
      s1_now_q      <= in_i.time_now_ms;
    end
    if (s1_fire) begin
      out_dup_q   <= is_dup;
      out_drops_q <= drops_new;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.is_duplicate  = out_dup_q;
  assign out_o.channel_drops = out_drops_q;

  // Checks.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_in_range_q |=> !out_dup_q && (out_drops_q == '0))
    else $error("out-of-range channel gave a nonzero result");

  a_dup_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && is_dup |-> (window_q != '0) && slot_hit)
    else $error("duplicate flagged without a valid slot or with zero window");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_ch_q) && $stable(s1_fp_q))
    else $error("stalled compare stage lost its item");

  a_no_write_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> ({1'b0, wr_req.idx} < (ChanW+1)'(CHANNELS)))
    else $error("table write to a channel out of range");

endmodule

`default_nettype wire

@@ tb/per_channel_duplicate_window_filter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_channel_duplicate_window_filter_core_tb
// Self-checking bench for the per-channel duplicate window filter. A queue of
// frames feeds a valid/ready driver. An in-bench copy of the channel table
// predicts the verdict of every accepted frame. A monitor checks each result
// item against the oldest prediction. The run steps through several window
// settings, from zero to the full 32-bit range, with random gaps on both
// sides, a long receiver hold-off and sender pauses.
// ----------------------------------------------------------------------------

module per_channel_duplicate_window_filter_core_tb;

  localparam int unsigned ChanW         = pcdwf_pkg::ChanW;
  localparam int unsigned DataW         = pcdwf_pkg::DataW;
  localparam logic [DataW-1:0] WindowReset = pcdwf_pkg::WindowReset;

  localparam int unsigned CHANNELS      = 8;
  localparam int unsigned GAP_PCT       = 22;    // idle odds per side, percent
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 5000;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [DataW-1:0] fingerprint;
    logic [DataW-1:0] time_ms;
  } frame_t;

  typedef struct packed {
    logic             dup;
    logic [DataW-1:0] drops;
  } verdict_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [DataW-1:0] cfg_wdata_i;

  pcdwf_in_if  frame_if ();
  pcdwf_out_if verdict_if ();

  per_channel_duplicate_window_filter_core #(
    .CHANNELS (CHANNELS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (frame_if),
    .out_o       (verdict_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the channel table and the window register.
  logic [DataW-1:0] window_model;
  logic             slot_valid [CHANNELS];
  logic [DataW-1:0] slot_fp    [CHANNELS];
  logic [DataW-1:0] slot_time  [CHANNELS];
  logic [DataW-1:0] drop_count [CHANNELS];

  frame_t   frame_queue [$];  // frames waiting to be driven
  verdict_t verdict_q   [$];  // predicted verdicts, oldest first

  // Stimulus shaping: last fingerprint/time queued per channel, plus a small
  // pool of fingerprints so that matches happen across channels too.
  logic [DataW-1:0] gen_fp   [16];
  logic [DataW-1:0] gen_t    [16];
  logic [DataW-1:0] fp_pool  [4];
  logic [DataW-1:0] stim_now;

  logic no_gaps  = 1'b0;   // both sides run without idling
  logic hold_arm = 1'b0;   // starts the long receiver hold-off
  logic hold_rx;
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch at result %0d: %s got 0x%08h want 0x%08h",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  // Verdict for one frame; updates the bench table the same way the block
  // should. Channels at or above CHANNELS yield zero and touch nothing.
  function automatic verdict_t predict_verdict(input frame_t f);
    verdict_t         v;
    logic [DataW-1:0] elapsed;
    v.dup   = 1'b0;
    v.drops = '0;
    if (f.channel < CHANNELS) begin
      // Elapsed time wraps mod 2^32, so a time that went backwards looks huge.
      elapsed = f.time_ms - slot_time[f.channel];
      if (slot_valid[f.channel] && slot_fp[f.channel] == f.fingerprint &&
          elapsed < window_model) begin
        // Duplicate: count it, keep the slot as it was.
        drop_count[f.channel] = drop_count[f.channel] + 1'b1;
        v.dup = 1'b1;
      end else begin
        slot_fp[f.channel]    = f.fingerprint;
        slot_time[f.channel]  = f.time_ms;
        slot_valid[f.channel] = 1'b1;
      end
      v.drops = drop_count[f.channel];
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: holds each frame until it is accepted, and only inserts random
  // gaps between items. The verdict is predicted at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : tx_drive
    frame_t nxt;
    frame_t sent;
    if (!rst_ni) begin
      frame_if.valid               <= 1'b0;
      frame_if.channel             <= '0;
      frame_if.message_fingerprint <= '0;
      frame_if.time_now_ms         <= '0;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        sent.channel     = frame_if.channel;
        sent.fingerprint = frame_if.message_fingerprint;
        sent.time_ms     = frame_if.time_now_ms;
        verdict_q.push_back(predict_verdict(sent));
      end
      if (!frame_if.valid || frame_if.ready) begin
        if (frame_queue.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          nxt = frame_queue.pop_front();
          frame_if.valid               <= 1'b1;
          frame_if.channel             <= nxt.channel;
          frame_if.message_fingerprint <= nxt.fingerprint;
          frame_if.time_now_ms         <= nxt.time_ms;
        end else begin
          frame_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // throttles ready at random, or holds it low during the long hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : rx_check
    verdict_t want;
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
    end else begin
      if (verdict_if.valid && verdict_if.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with nothing pending", verdict_if.channel_drops, '0);
        end else begin
          want = verdict_q.pop_front();
          if (verdict_if.is_duplicate !== want.dup)
            report_mismatch("is_duplicate", DataW'(verdict_if.is_duplicate),
                            DataW'(want.dup));
          if (verdict_if.channel_drops !== want.drops)
            report_mismatch("channel_drops", verdict_if.channel_drops, want.drops);
        end
        result_count++;
      end
      verdict_if.ready <= !hold_rx && (no_gaps || $urandom_range(99) >= GAP_PCT);
    end
  end

  // Long receiver stall, counted here so the sender keeps offering frames and
  // the block backs up until its input stalls.
  initial begin : rx_holdoff
    hold_rx = 1'b0;
    wait (hold_arm);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  task automatic add_frame(input logic [ChanW-1:0] ch, input logic [DataW-1:0] fp,
                           input logic [DataW-1:0] t);
    frame_t f;
    f.channel     = ch;
    f.fingerprint = fp;
    f.time_ms     = t;
    gen_fp[ch]    = fp;
    gen_t[ch]     = t;
    frame_queue.push_back(f);
  endtask

  // Random traffic: mostly repeats of a channel's last fingerprint at times
  // that step around the window, with some fresh fingerprints, time jumps
  // anywhere in the 32-bit range and out-of-range channels mixed in.
  task automatic queue_random_frames(input int unsigned count);
    logic [ChanW-1:0] ch;
    logic [DataW-1:0] fp;
    logic [DataW-1:0] t;
    int unsigned      pick;
    int unsigned      span;
    span = (window_model < 16) ? 4 : (window_model > 1600) ? 400 : window_model >> 2;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      ch   = (pick < 90) ? ChanW'($urandom_range(CHANNELS - 1))
                         : ChanW'($urandom_range(15, CHANNELS));
      pick = $urandom_range(99);
      if (pick < 45)      fp = gen_fp[ch];
      else if (pick < 75) fp = fp_pool[$urandom_range(3)];
      else                fp = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) begin
        stim_now = $urandom;
        t = stim_now;
      end else if (pick < 23) begin
        // Right at the window edge of the channel's last frame.
        t = gen_t[ch] + window_model + $urandom_range(2) - 1;
      end else begin
        stim_now = stim_now + $urandom_range(2 * span);
        t = stim_now;
      end
      add_frame(ch, fp, t);
    end
  endtask

  task automatic wait_drained();
    while (frame_queue.size() != 0 || frame_if.valid || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_window(input logic [DataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    window_model = value;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned spin;
    rst_ni                       = 1'b0;
    cfg_we_i                     = 1'b0;
    cfg_wdata_i                  = '0;
    window_model                 = WindowReset;
    for (int i = 0; i < CHANNELS; i++) begin
      slot_valid[i] = 1'b0;
      slot_fp[i]    = '0;
      slot_time[i]  = '0;
      drop_count[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      gen_fp[i] = $urandom;
      gen_t[i]  = '0;
    end
    for (int i = 0; i < 4; i++) fp_pool[i] = $urandom;
    stim_now = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset window of 50 ms.
    add_frame(0, 32'h1234_5678, 32'd100);        // first use of a slot
    add_frame(0, 32'h1234_5678, 32'd149);        // one below the window: drop
    add_frame(0, 32'h1234_5678, 32'd150);        // exactly the window: accept
    add_frame(0, 32'h1234_5678, 32'd150);        // zero elapsed: drop
    add_frame(0, 32'h1234_5679, 32'd151);        // new fingerprint
    add_frame(1, 32'h0000_0000, 32'h0000_0000);  // zero fp on an empty slot
    add_frame(1, 32'h0000_0000, 32'h0000_0000);
    add_frame(8, 32'hFFFF_FFFF, 32'h0000_0000);  // channels out of range
    add_frame(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_frame(2, 32'hDEAD_BEEF, 32'hFFFF_FFF0);  // time wraps past 2^32
    add_frame(2, 32'hDEAD_BEEF, 32'h0000_0010);
    add_frame(3, 32'hA5A5_5A5A, 32'd1000);       // time goes backwards
    add_frame(3, 32'hA5A5_5A5A, 32'd999);
    add_frame(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_frame(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_frame(6, 32'h5555_AAAA, 32'h8000_0000);
    add_frame(6, 32'h5555_AAAA, 32'h8000_0031);
    queue_random_frames(200);
    wait_drained();

    // Zero window: nothing is ever a duplicate.
    write_window('0);
    add_frame(5, 32'h0F0F_F0F0, 32'd77);
    add_frame(5, 32'h0F0F_F0F0, 32'd77);
    queue_random_frames(200);
    wait_drained();

    // Full window: only an elapsed time of all ones escapes.
    write_window(32'hFFFF_FFFF);
    add_frame(4, 32'h3C3C_C3C3, 32'd10);
    add_frame(4, 32'h3C3C_C3C3, 32'd9);
    add_frame(4, 32'h3C3C_C3C3, 32'd7);
    queue_random_frames(200);
    wait_drained();

    // Receiver stalls for a long stretch while frames keep coming.
    write_window(32'd1000);
    hold_arm <= 1'b1;
    queue_random_frames(250);
    wait_drained();

    // One-ms window; the sender pauses halfway until every result is in.
    write_window(32'd1);
    queue_random_frames(150);
    wait_drained();
    queue_random_frames(150);
    wait_drained();

    // Back-to-back traffic on both sides with a random window.
    no_gaps <= 1'b1;
    write_window($urandom);
    queue_random_frames(250);
    wait_drained();
    no_gaps <= 1'b0;

    write_window(WindowReset);
    queue_random_frames(200);

    spin = 0;
    while ((frame_queue.size() != 0 || frame_if.valid || verdict_q.size() != 0) &&
           spin < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch("results never arrived", verdict_q.size(), '0);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
